// ----- sv/rational_arithmetic_unit_core_macros.svh -----
// assertion macros shared by the checker
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

// property checked outside reset
`define RAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked during reset as well
`define RAU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/rau_pkg.sv -----
package rau_pkg;

    // default operand width
    localparam int OPERAND_WIDTH_DEF = 32;
    // port field width
    localparam int FIELD_W = 32;
    // magnitude width of products and sums
    localparam int MAG_W = 64;
    // one quotient bit per step
    localparam int DIV_STEPS = MAG_W;
    localparam int CNT_W = $clog2(DIV_STEPS);
    // shift count of the binary gcd
    localparam int K_W = $clog2(MAG_W) + 1;

    // operation codes
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    // product slots of the shared multiplier
    localparam logic [1:0] PROD_LN_RD = 2'd0;
    localparam logic [1:0] PROD_RN_LD = 2'd1;
    localparam logic [1:0] PROD_LD_RD = 2'd2;
    localparam logic [1:0] PROD_LN_RN = 2'd3;

    // divider operand select
    localparam logic DIV_SEL_NUM = 1'b0;
    localparam logic DIV_SEL_DEN = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       form;
        logic       gcd_step;
        logic       g_load;
        logic       shl_step;
        logic       div_init;
        logic       div_sel;
        logic       div_step;
        logic       div_store;
        logic       out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic gcd_done;
        logic k_zero;
    } sts_t;

endpackage

// ----- sv/rau_ctrl.sv -----
module rau_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  rau_pkg::sts_t sts,
    output rau_pkg::cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_MUL     = 11'b000_0000_0010,
        ST_FORM    = 11'b000_0000_0100,
        ST_GCD     = 11'b000_0000_1000,
        ST_GSHIFT  = 11'b000_0001_0000,
        ST_DINIT_N = 11'b000_0010_0000,
        ST_DIV_N   = 11'b000_0100_0000,
        ST_DINIT_D = 11'b000_1000_0000,
        ST_DIV_D   = 11'b001_0000_0000,
        ST_STORE_D = 11'b010_0000_0000,
        ST_FIN     = 11'b100_0000_0000
    } state_t;

    localparam logic [rau_pkg::CNT_W-1:0] CNT_LAST = rau_pkg::CNT_W'(rau_pkg::DIV_STEPS - 1);
    localparam logic [rau_pkg::CNT_W-1:0] MUL_LAST = rau_pkg::CNT_W'(3);

    state_t                    state_reg, state_next;
    logic [rau_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      valid_reg, valid_next;

    // state and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // sequencing
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.mul_sel = cnt_reg[1:0];
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_FORM;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FORM: begin
                cmd.form   = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (sts.gcd_done) begin
                    cmd.g_load = 1'b1;
                    state_next = ST_GSHIFT;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_GSHIFT: begin
                if (sts.k_zero) begin
                    state_next = ST_DINIT_N;
                end else begin
                    cmd.shl_step = 1'b1;
                end
            end
            ST_DINIT_N: begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = rau_pkg::DIV_SEL_NUM;
                cnt_next     = '0;
                state_next   = ST_DIV_N;
            end
            ST_DIV_N: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_DINIT_D;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DINIT_D: begin
                // numerator quotient is stored as the denominator loads
                cmd.div_store = 1'b1;
                cmd.div_init  = 1'b1;
                cmd.div_sel   = rau_pkg::DIV_SEL_DEN;
                cnt_next      = '0;
                state_next    = ST_DIV_D;
            end
            ST_DIV_D: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_STORE_D;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_STORE_D: begin
                cmd.div_store = 1'b1;
                cmd.div_sel   = rau_pkg::DIV_SEL_DEN;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        valid_next = valid_reg;
        priority if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

// ----- sv/rau_dp.sv -----
module rau_dp #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                        aclk,
    input  rau_pkg::cmd_t               cmd,
    output rau_pkg::sts_t               sts,
    input  logic [1:0]                  in_func,
    input  logic [rau_pkg::FIELD_W-1:0] in_lhs_num,
    input  logic [rau_pkg::FIELD_W-1:0] in_lhs_den,
    input  logic [rau_pkg::FIELD_W-1:0] in_rhs_num,
    input  logic [rau_pkg::FIELD_W-1:0] in_rhs_den,
    output logic [rau_pkg::FIELD_W-1:0] res_num,
    output logic [rau_pkg::FIELD_W-1:0] res_den,
    output logic                        overflow,
    output logic                        undefined,
    output logic                        lhs_greater,
    output logic                        lhs_equal,
    output logic                        lhs_less
);

    localparam int FW = rau_pkg::FIELD_W;
    localparam int MW = rau_pkg::MAG_W;
    localparam int KW = rau_pkg::K_W;
    localparam int SH = FW - OPERAND_WIDTH;
    localparam logic [MW-1:0] LIMIT = MW'(1) << (OPERAND_WIDTH - 1);

    // low operand bits, sign extended
    function automatic logic signed [FW-1:0] sext_op(input logic [FW-1:0] v);
        sext_op = $signed(v << SH) >>> SH;
    endfunction

    logic [1:0]                func_reg;
    logic signed [FW-1:0]      ln_reg, ld_reg, rn_reg, rd_reg;
    logic signed [2*FW-1:0]    prod_reg [4];
    logic signed [FW-1:0]      mul_a, mul_b;
    logic                      gt_reg, eq_reg, lt_reg;
    logic                      nneg_reg, dneg_reg;
    logic [MW-1:0]             nmag_reg, dmag_reg;
    logic [MW-1:0]             a_reg, b_reg, g_reg;
    logic [KW-1:0]             k_reg;
    logic [MW-1:0]             q_reg, nq_reg, dq_reg;
    logic [MW-1:0]             rem_reg;
    logic [FW-1:0]             res_num_reg, res_den_reg;
    logic                      ovf_reg, undef_reg;
    logic                      cgt_reg, ceq_reg, clt_reg;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            ln_reg   <= sext_op(in_lhs_num);
            ld_reg   <= sext_op(in_lhs_den);
            rn_reg   <= sext_op(in_rhs_num);
            rd_reg   <= sext_op(in_rhs_den);
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (cmd.mul_sel)
            rau_pkg::PROD_LN_RD: begin mul_a = ln_reg; mul_b = rd_reg; end
            rau_pkg::PROD_RN_LD: begin mul_a = rn_reg; mul_b = ld_reg; end
            rau_pkg::PROD_LD_RD: begin mul_a = ld_reg; mul_b = rd_reg; end
            rau_pkg::PROD_LN_RN: begin mul_a = ln_reg; mul_b = rn_reg; end
            default:             begin mul_a = ln_reg; mul_b = rd_reg; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg[cmd.mul_sel] <= mul_a * mul_b;
        end
    end

    // numerator and denominator forming
    logic signed [2*FW:0]   p1_x, p2_x, n_full;
    logic signed [2*FW-1:0] d_full;
    logic [2*FW:0]          n_abs;
    logic [2*FW-1:0]        d_abs;

    always_comb begin
        p1_x = {prod_reg[rau_pkg::PROD_LN_RD][2*FW-1], prod_reg[rau_pkg::PROD_LN_RD]};
        p2_x = {prod_reg[rau_pkg::PROD_RN_LD][2*FW-1], prod_reg[rau_pkg::PROD_RN_LD]};
        unique case (func_reg)
            rau_pkg::FUNC_ADD: begin
                n_full = p1_x + p2_x;
                d_full = prod_reg[rau_pkg::PROD_LD_RD];
            end
            rau_pkg::FUNC_SUB: begin
                n_full = p1_x - p2_x;
                d_full = prod_reg[rau_pkg::PROD_LD_RD];
            end
            rau_pkg::FUNC_MUL: begin
                n_full = {prod_reg[rau_pkg::PROD_LN_RN][2*FW-1],
                          prod_reg[rau_pkg::PROD_LN_RN]};
                d_full = prod_reg[rau_pkg::PROD_LD_RD];
            end
            rau_pkg::FUNC_DIV: begin
                n_full = p1_x;
                d_full = prod_reg[rau_pkg::PROD_RN_LD];
            end
            default: begin
                n_full = p1_x;
                d_full = prod_reg[rau_pkg::PROD_RN_LD];
            end
        endcase
        n_abs = n_full[2*FW] ? -n_full : n_full;
        d_abs = d_full[2*FW-1] ? -d_full : d_full;
    end

    always_ff @(posedge aclk) begin
        if (cmd.form) begin
            nneg_reg <= n_full[2*FW];
            dneg_reg <= d_full[2*FW-1];
            nmag_reg <= MW'(n_abs);
            dmag_reg <= MW'(d_abs);
            gt_reg   <= p1_x > p2_x;
            eq_reg   <= p1_x == p2_x;
            lt_reg   <= p1_x < p2_x;
        end
    end

    // binary gcd, one step per cycle, then shift back the common twos
    always_ff @(posedge aclk) begin
        if (cmd.form) begin
            a_reg <= MW'(n_abs);
            b_reg <= MW'(d_abs);
            k_reg <= '0;
        end else if (cmd.gcd_step) begin
            priority if (!a_reg[0] && !b_reg[0]) begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!a_reg[0]) begin
                a_reg <= a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_reg <= b_reg >> 1;
            end else if (a_reg >= b_reg) begin
                a_reg <= (a_reg - b_reg) >> 1;
            end else begin
                b_reg <= (b_reg - a_reg) >> 1;
            end
        end else if (cmd.shl_step) begin
            k_reg <= k_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.g_load) begin
            g_reg <= a_reg | b_reg;
        end else if (cmd.shl_step) begin
            g_reg <= g_reg << 1;
        end
    end

    assign sts.gcd_done = (a_reg == '0) || (b_reg == '0);
    assign sts.k_zero   = (k_reg == '0);

    // restoring divider, one quotient bit per cycle
    logic [MW:0] rem_sh;
    logic        rem_ge;

    assign rem_sh = {rem_reg, q_reg[MW-1]};
    assign rem_ge = rem_sh >= {1'b0, g_reg};

    // remainder stays below the gcd, so it fits in MW bits
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            q_reg   <= (cmd.div_sel == rau_pkg::DIV_SEL_DEN) ? dmag_reg : nmag_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? MW'(rem_sh - {1'b0, g_reg}) : rem_sh[MW-1:0];
            q_reg   <= {q_reg[MW-2:0], rem_ge};
        end
    end

    // numerator quotient is stored while the denominator loads
    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            if (cmd.div_init) begin
                nq_reg <= q_reg;
            end else begin
                dq_reg <= q_reg;
            end
        end
    end

    // range check and field forming
    logic          undef_c, ovfn, ovfd;
    logic [MW-1:0] nbits, dbits;

    always_comb begin
        undef_c = (g_reg == '0);
        ovfn    = nneg_reg ? (nq_reg > LIMIT) : (nq_reg >= LIMIT);
        ovfd    = dneg_reg ? (dq_reg > LIMIT) : (dq_reg >= LIMIT);
        nbits   = nneg_reg ? -nq_reg : nq_reg;
        dbits   = dneg_reg ? -dq_reg : dq_reg;
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_num_reg <= undef_c ? '0 : sext_op(nbits[FW-1:0]);
            res_den_reg <= undef_c ? '0 : sext_op(dbits[FW-1:0]);
            ovf_reg     <= !undef_c && (ovfn || ovfd);
            undef_reg   <= undef_c;
            cgt_reg     <= gt_reg;
            ceq_reg     <= eq_reg;
            clt_reg     <= lt_reg;
        end
    end

    assign res_num     = res_num_reg;
    assign res_den     = res_den_reg;
    assign overflow    = ovf_reg;
    assign undefined   = undef_reg;
    assign lhs_greater = cgt_reg;
    assign lhs_equal   = ceq_reg;
    assign lhs_less    = clt_reg;

endmodule

// ----- sv/rational_arithmetic_unit_core.sv -----
// rational arithmetic unit
// input channel s_*: one word holds two fractions, s_tuser holds the operation
// (add, subtract, multiply, divide); a word is taken while the unit is idle
// output channel m_*: reduced numerator and denominator, the comparison flags
// of lhs_num*rhs_den against rhs_num*lhs_den, and overflow / undefined in m_tuser
// operands use their low OPERAND_WIDTH bits, results are sign extended to 32 bits
// the work runs in order: the four products, forming numerator and denominator,
// the binary gcd steps, the shift back by the common factors of two, then the
// divisions of numerator and denominator by the gcd; the gcd loop takes one
// step per cycle; one item is worked on at a time
// a finished word waits in the output register; the next input word is taken
// meanwhile, and its result is held back until the waiting word is taken
// reset clears the controller and drops m_tvalid; no result is in flight after it
module rational_arithmetic_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lhs_num[31:0], lhs_den[63:32], rhs_num[95:64], rhs_den[127:96]
    input  logic [127:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num[31:0], res_den[63:32], lhs_greater[64], lhs_equal[65],
    // lhs_less[66], zero fill[71:67]
    output logic [71:0]  m_tdata,
    // overflow[0], undefined[1]
    output logic [1:0]   m_tuser
);

    rau_pkg::cmd_t cmd;
    rau_pkg::sts_t sts;
    logic [31:0]   res_num, res_den;
    logic          overflow, undefined, lhs_greater, lhs_equal, lhs_less;

    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rau_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .sts         (sts),
        .in_func     (s_tuser),
        .in_lhs_num  (s_tdata[31:0]),
        .in_lhs_den  (s_tdata[63:32]),
        .in_rhs_num  (s_tdata[95:64]),
        .in_rhs_den  (s_tdata[127:96]),
        .res_num     (res_num),
        .res_den     (res_den),
        .overflow    (overflow),
        .undefined   (undefined),
        .lhs_greater (lhs_greater),
        .lhs_equal   (lhs_equal),
        .lhs_less    (lhs_less)
    );

    // output word packing
    assign m_tdata = {5'b0, lhs_less, lhs_equal, lhs_greater, res_den, res_num};
    assign m_tuser = {undefined, overflow};

endmodule

// ----- sv/rau_checker.sv -----
`include "rational_arithmetic_unit_core_macros.svh"

module rau_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [127:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    // a stalled word stays offered
    `RAU_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

    // exactly one comparison flag per word
    `RAU_ASSERT(a_cmp_onehot, m_tvalid |-> $onehot(m_tdata[66:64]), "comparison flags not one-hot")

    // zero over zero gives zero fields and no overflow
    `RAU_ASSERT(a_undef_zero, m_tvalid && m_tuser[1] |-> m_tdata[63:0] == 64'd0 && !m_tuser[0], "undefined result not cleared")

    // no word leaves right after reset
    `RAU_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid, "m_tvalid after reset")

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);
